### hdl/assert_macros.svh
// -----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion helpers, empty for synthesis
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

### hdl/spmq_pkg.sv
// -----------------------------------------------------------------------------
// spmq_pkg
// shared types and codes of the strict priority message queue
// -----------------------------------------------------------------------------
package spmq_pkg;

  localparam int unsigned HandleW = 32;
  localparam int unsigned TypeW   = 8;
  localparam int unsigned PrioW   = 8;
  localparam int unsigned TimeW   = 64;
  localparam int unsigned OutPriW = 3;
  localparam int unsigned CountW  = 8;

  localparam logic KindEnq = 1'b0;
  localparam logic KindDeq = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_INVALID = 2'd1,
    STATUS_EMPTY   = 2'd2,
    STATUS_FULL    = 2'd3
  } status_e;

  typedef enum logic {
    ST_IDLE,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic exec;
    logic respond;
  } cmd_t;

  typedef struct packed {
    logic [HandleW-1:0] handle;
    logic [TypeW-1:0]   mtype;
    logic [TimeW-1:0]   stamp;
  } entry_t;

endpackage

### hdl/spmq_ctrl.sv
// -----------------------------------------------------------------------------
// spmq_ctrl
// transaction sequencer: accepts a command, then strobes its result
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module spmq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  output logic              done_o,
  output spmq_pkg::cmd_t    cmd_o
);
  import spmq_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o.exec    = 1'b0;
    cmd_o.respond = 1'b0;
    busy_o        = 1'b0;
    done_o        = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.exec = 1'b1;
          state_d    = ST_RESP;
        end
      end
      ST_RESP: begin
        busy_o        = 1'b1;
        done_o        = 1'b1;
        cmd_o.respond = 1'b1;
        state_d       = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  `ASSERT_NEXT(a_exec_then_resp, clk_i, rst_ni, cmd_o.exec, cmd_o.respond && done_o)
  `ASSERT_NEXT(a_resp_single, clk_i, rst_ni, cmd_o.respond, !cmd_o.respond)
  `ASSERT_IMPLIES(a_exec_when_idle, clk_i, rst_ni, cmd_o.exec, !busy_o && !done_o)

endmodule

### hdl/spmq_datapath.sv
// -----------------------------------------------------------------------------
// spmq_datapath
// per-level fifo pointers, message memory and result registers
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module spmq_datapath #(
  parameter int unsigned PriorityLevels = 4,
  parameter int unsigned LevelDepth     = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  spmq_pkg::cmd_t                cmd_i,
  input  logic                          kind_i,
  input  logic [spmq_pkg::HandleW-1:0]  message_handle_i,
  input  logic [spmq_pkg::TypeW-1:0]    message_type_i,
  input  logic [spmq_pkg::PrioW-1:0]    priority_req_i,
  input  logic [spmq_pkg::TimeW-1:0]    timestamp_i,
  input  logic                          cfg_we_i,
  input  logic [spmq_pkg::TypeW-1:0]    cfg_data_i,
  output logic [1:0]                    status_o,
  output logic [spmq_pkg::HandleW-1:0]  out_handle_o,
  output logic [spmq_pkg::TypeW-1:0]    out_type_o,
  output logic [spmq_pkg::OutPriW-1:0]  out_priority_o,
  output logic [spmq_pkg::TimeW-1:0]    out_timestamp_o,
  output logic [spmq_pkg::CountW-1:0]   total_count_o
);
  import spmq_pkg::*;

  localparam int unsigned LvlW     = (PriorityLevels > 1) ? $clog2(PriorityLevels) : 1;
  localparam int unsigned PtrW     = $clog2(LevelDepth);
  localparam int unsigned CntW     = $clog2(LevelDepth + 1);
  localparam int unsigned TotW     = $clog2(PriorityLevels * LevelDepth + 1);
  localparam int unsigned AddrW    = LvlW + PtrW;
  localparam int unsigned MemDepth = PriorityLevels * (2 ** PtrW);

  logic [TypeW-1:0] inv_type_q;

  logic [PtrW-1:0] head_q [PriorityLevels];
  logic [PtrW-1:0] tail_q [PriorityLevels];
  logic [CntW-1:0] cnt_q  [PriorityLevels];
  logic [TotW-1:0] total_q;

  entry_t mem [MemDepth];
  entry_t rd_q;

  status_e         status_q, status_d;
  logic            hit_q;
  logic [LvlW-1:0] out_lvl_q;

  logic            is_deq, pri_ok, type_ok, found, full;
  logic            enq_ok, deq_ok;
  logic [LvlW-1:0] deq_lvl, lvl;
  logic [PtrW-1:0] ptr, ptr_next;
  logic [AddrW-1:0] addr;
  entry_t          wr_entry;

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_type_q <= '0;
    end else if (cfg_we_i) begin
      inv_type_q <= cfg_data_i;
    end
  end

  // lowest-numbered non-empty level
  always_comb begin
    found   = 1'b0;
    deq_lvl = '0;
    for (int l = PriorityLevels - 1; l >= 0; l--) begin
      if (cnt_q[l] != '0) begin
        found   = 1'b1;
        deq_lvl = LvlW'(l);
      end
    end
  end

  always_comb begin
    is_deq  = (kind_i == KindDeq);
    pri_ok  = (priority_req_i < PrioW'(PriorityLevels));
    type_ok = (message_type_i != inv_type_q);
    lvl     = is_deq ? deq_lvl : priority_req_i[LvlW-1:0];
    if (32'(lvl) >= PriorityLevels) begin
      lvl = '0;
    end
    full     = (cnt_q[lvl] == CntW'(LevelDepth));
    enq_ok   = !is_deq && pri_ok && type_ok && !full;
    deq_ok   = is_deq && found;
    ptr      = is_deq ? head_q[lvl] : tail_q[lvl];
    ptr_next = (ptr == PtrW'(LevelDepth - 1)) ? '0 : ptr + PtrW'(1);
    addr     = {lvl, ptr};
    wr_entry = '{handle: message_handle_i, mtype: message_type_i, stamp: timestamp_i};
    priority if (is_deq) begin
      status_d = found ? STATUS_OK : STATUS_EMPTY;
    end else if (!pri_ok || !type_ok) begin
      status_d = STATUS_INVALID;
    end else if (full) begin
      status_d = STATUS_FULL;
    end else begin
      status_d = STATUS_OK;
    end
  end

  // pointers and counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < PriorityLevels; l++) begin
        head_q[l] <= '0;
        tail_q[l] <= '0;
        cnt_q[l]  <= '0;
      end
      total_q <= '0;
    end else if (cmd_i.exec) begin
      if (enq_ok) begin
        tail_q[lvl] <= ptr_next;
        cnt_q[lvl]  <= cnt_q[lvl] + CntW'(1);
        total_q     <= total_q + TotW'(1);
      end else if (deq_ok) begin
        head_q[lvl] <= ptr_next;
        cnt_q[lvl]  <= cnt_q[lvl] - CntW'(1);
        total_q     <= total_q - TotW'(1);
      end
    end
  end

  // message memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && enq_ok) begin
      mem[addr] <= wr_entry;
    end
    if (cmd_i.exec && deq_ok) begin
      rd_q <= mem[addr];
    end
  end

  // result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q  <= STATUS_OK;
      hit_q     <= 1'b0;
      out_lvl_q <= '0;
    end else if (cmd_i.exec) begin
      status_q  <= status_d;
      hit_q     <= deq_ok;
      out_lvl_q <= lvl;
    end
  end

  always_comb begin
    status_o        = cmd_i.respond ? status_q : STATUS_OK;
    out_handle_o    = '0;
    out_type_o      = '0;
    out_priority_o  = '0;
    out_timestamp_o = '0;
    if (cmd_i.respond && hit_q) begin
      out_handle_o    = rd_q.handle;
      out_type_o      = rd_q.mtype;
      out_priority_o  = OutPriW'(out_lvl_q);
      out_timestamp_o = rd_q.stamp;
    end
    total_count_o = CountW'(total_q);
  end

  `ASSERT_IMPLIES(a_total_bound, clk_i, rst_ni, 1'b1, total_q <= TotW'(PriorityLevels * LevelDepth))
  `ASSERT_NEXT(a_enq_counts, clk_i, rst_ni, cmd_i.exec && enq_ok, total_q == $past(total_q) + TotW'(1))
  `ASSERT_IMPLIES(a_empty_total, clk_i, rst_ni, cmd_i.exec && is_deq && !found, total_q == '0)

endmodule

### hdl/strict_priority_message_queue.sv
// -----------------------------------------------------------------------------
// strict_priority_message_queue
// one fifo per priority level; dequeue serves the lowest-numbered non-empty level
// -----------------------------------------------------------------------------
// usage:
//   command channel: drive kind_i and the message fields with start high; the
//   transaction is taken at a clock edge where start is high and busy is low.
//   kind_i low enqueues, kind_i high dequeues (message fields ignored).
//   result channel: done_o is high for exactly one cycle, the cycle after the
//   command is taken, with status_o, the dequeued message and total_count_o.
//   the receiver cannot stall; the result must be captured in that cycle.
//   busy is high during the result cycle, so no new command is taken
//   before the result of the last one has been given.
//   config: cfg_data_i is written into the invalid type code register when
//   cfg_valid_i and cfg_ready_o are both high; write it only while idle.
//   reset: all levels empty, total count zero, invalid type code zero. the
//   message memory needs no clearing, only held entries are ever read.
// -----------------------------------------------------------------------------
module strict_priority_message_queue #(
  parameter int unsigned PriorityLevels = 4,
  parameter int unsigned LevelDepth     = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          kind_i,
  input  logic [spmq_pkg::HandleW-1:0]  message_handle_i,
  input  logic [spmq_pkg::TypeW-1:0]    message_type_i,
  input  logic [spmq_pkg::PrioW-1:0]    priority_req_i,
  input  logic [spmq_pkg::TimeW-1:0]    timestamp_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [spmq_pkg::TypeW-1:0]    cfg_data_i,
  output logic                          done_o,
  output logic [1:0]                    status_o,
  output logic [spmq_pkg::HandleW-1:0]  out_handle_o,
  output logic [spmq_pkg::TypeW-1:0]    out_type_o,
  output logic [spmq_pkg::OutPriW-1:0]  out_priority_o,
  output logic [spmq_pkg::TimeW-1:0]    out_timestamp_o,
  output logic [spmq_pkg::CountW-1:0]   total_count_o
);
  import spmq_pkg::*;

  cmd_t cmd;
  logic cfg_we;

  assign cfg_ready_o = !busy;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  spmq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .done_o  (done_o),
    .cmd_o   (cmd)
  );

  spmq_datapath #(
    .PriorityLevels (PriorityLevels),
    .LevelDepth     (LevelDepth)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .kind_i           (kind_i),
    .message_handle_i (message_handle_i),
    .message_type_i   (message_type_i),
    .priority_req_i   (priority_req_i),
    .timestamp_i      (timestamp_i),
    .cfg_we_i         (cfg_we),
    .cfg_data_i       (cfg_data_i),
    .status_o         (status_o),
    .out_handle_o     (out_handle_o),
    .out_type_o       (out_type_o),
    .out_priority_o   (out_priority_o),
    .out_timestamp_o  (out_timestamp_o),
    .total_count_o    (total_count_o)
  );

endmodule
